### hw/rtl/bs3_pkg.sv
// ----------------------------------------------------------------------------
// bs3_pkg
// Shared constants, types and helpers for the 3x3 box-sum filter.
// ----------------------------------------------------------------------------
package bs3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int ROW_BITS    = 12;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = 11;
    localparam int COLSUM_BITS = SAMPLE_BITS + 2;
    localparam int SUM_BITS    = SAMPLE_BITS + 4;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(640);
    localparam logic [WIDTH_BITS-1:0] WIDTH_MIN   = WIDTH_BITS'(3);
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [ROW_BITS-1:0]   ROW_MAX     = {ROW_BITS{1'b1}};

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COLSUM_BITS-1:0] t_colsum;
    typedef logic signed [SUM_BITS-1:0]    t_sum;
    typedef logic [COL_BITS-1:0]           t_col;
    typedef logic [ROW_BITS-1:0]           t_row;
    typedef logic [WIDTH_BITS-1:0]         t_width;

    // word in flight between the scan counters and the line stores
    typedef struct packed {
        logic    valid;
        t_sample sample;
        logic    fend;
        t_col    col;
        t_row    row;
    } t_item;

    // column sum on its way to the window
    typedef struct packed {
        logic    valid;
        logic    emit;
        logic    fend;
        t_colsum colsum;
        t_row    out_row;
        t_col    out_col;
    } t_col_item;

    // scan position counters
    typedef struct packed {
        t_col col;
        t_row row;
    } t_pos;

    function automatic t_width eff_width(input t_width w);
        t_width res;
        res = w;
        if (w < WIDTH_MIN) begin
            res = WIDTH_MIN;
        end else if (w > WIDTH_MAX) begin
            res = WIDTH_MAX;
        end
        return res;
    endfunction

endpackage

### hw/rtl/box_sum_3x3_valid.sv
// ----------------------------------------------------------------------------
// box_sum_3x3_valid
// Streaming 3x3 box sum over a row-major matrix, valid positions only.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        sink       i_in_valid / o_in_ready    i_sample, i_frame_end
//  out       source     o_out_valid / i_out_ready  o_window_sum, o_out_row,
//                                                  o_out_col, o_last
//  cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_data (image width)
//
//  One word per cycle while the output register is not stalled; each word passes
//  the registered stages line-store read, column sum and window sum.
//  The rate is set by the one read and one write port of each line store.
//  The whole pipeline holds while the output register is full and not taken.
//  Reset clears counters, window and pipeline valids; line stores keep no
//  reset value and are read only for rows already written.
// ----------------------------------------------------------------------------
module box_sum_3x3_valid
    import bs3_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_sample i_sample,
    input  logic    i_frame_end,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_sum    o_window_sum,
    output t_row    o_out_row,
    output t_col    o_out_col,
    output logic    o_last,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  t_width  i_cfg_data
);

    t_width    r_width;
    t_width    width_eff;
    logic      advance;
    logic      rd_en;
    t_col      rd_addr;
    t_item     b_item;
    t_pos      pos;
    t_col_item c_col;
    t_colsum   r_win0, r_win1;
    logic      r_out_valid;
    t_sum      r_sum;
    t_row      r_out_row;
    t_col      r_out_col;
    logic      r_last;

    assign o_cfg_ready = 1'b1;
    assign width_eff   = eff_width(r_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_data;
        end
    end

    // advance everything unless a result waits in the output register and is not taken
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = advance;

    bs3_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_in_valid  (i_in_valid),
        .i_sample    (i_sample),
        .i_frame_end (i_frame_end),
        .i_width     (width_eff),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_item      (b_item),
        .o_pos       (pos)
    );

    bs3_lines u_lines (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_item    (b_item),
        .o_col     (c_col)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0      <= '0;
            r_win1      <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= c_col.valid && c_col.emit;
            if (c_col.valid) begin
                if (c_col.fend) begin
                    r_win0 <= '0;
                    r_win1 <= '0;
                end else begin
                    r_win0 <= r_win1;
                    r_win1 <= c_col.colsum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && c_col.valid) begin
            r_sum     <= t_sum'(r_win0) + t_sum'(r_win1) + t_sum'(c_col.colsum);
            r_out_row <= c_col.out_row;
            r_out_col <= c_col.out_col;
            r_last    <= c_col.fend;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_sum = r_sum;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_last       = r_last;

    a_frame_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_frame_end) |=> (pos.col == '0 && pos.row == '0))
        else $error("counters not cleared after frame end");

    a_stage_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_item.valid && !advance) |=>
            (b_item.valid && $stable(b_item.col) && $stable(b_item.sample)))
        else $error("line-store stage lost its word during a stall");

    a_col_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_col <= t_col'(MAX_WIDTH - 3)))
        else $error("result column beyond the valid range");

endmodule

### hw/rtl/bs3_ram.sv
// ----------------------------------------------------------------------------
// bs3_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bs3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bs3_scan.sv
// ----------------------------------------------------------------------------
// bs3_scan
// Column/row counters, line-store read issue and the first pipeline stage.
// ----------------------------------------------------------------------------
module bs3_scan
    import bs3_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  logic    i_in_valid,
    input  t_sample i_sample,
    input  logic    i_frame_end,
    input  t_width  i_width,
    output logic    o_rd_en,
    output t_col    o_rd_addr,
    output t_item   o_item,
    output t_pos    o_pos
);

    t_col  r_col, n_col;
    t_row  r_row, n_row;
    t_item r_item;
    logic  accept;
    t_width col_inc;

    assign accept  = i_in_valid && i_advance;
    assign col_inc = {1'b0, r_col} + t_width'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (i_frame_end) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc >= i_width) begin
                n_col = '0;
                // saturate the row index
                if (r_row != ROW_MAX) begin
                    n_row = r_row + t_row'(1);
                end
            end else begin
                n_col = col_inc[COL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_item <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_advance) begin
                r_item.valid <= accept;
                if (accept) begin
                    r_item.sample <= i_sample;
                    r_item.fend   <= i_frame_end;
                    r_item.col    <= r_col;
                    r_item.row    <= r_row;
                end
            end
        end
    end

    assign o_rd_en   = accept;
    assign o_rd_addr = r_col;
    assign o_item    = r_item;
    assign o_pos     = '{col: r_col, row: r_row};

endmodule

### hw/rtl/bs3_lines.sv
// ----------------------------------------------------------------------------
// bs3_lines
// Two line stores: read the rows above, shift the column down, sum it.
// ----------------------------------------------------------------------------
module bs3_lines
    import bs3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  logic      i_rd_en,
    input  t_col      i_rd_addr,
    input  t_item     i_item,
    output t_col_item o_col
);

    t_sample   rd_a, rd_b;
    t_sample   up1, up2;
    logic      we;
    t_col_item r_col;

    assign we = i_advance && i_item.valid;

    bs3_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_item.col),
        .i_wdata (i_item.sample),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_a)
    );

    bs3_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_item.col),
        .i_wdata (up1),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_b)
    );

    // rows not yet written count as zero
    assign up1 = (i_item.row >= t_row'(1)) ? rd_a : '0;
    assign up2 = (i_item.row >= t_row'(2)) ? rd_b : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_advance) begin
            r_col.valid <= i_item.valid;
            if (i_item.valid) begin
                r_col.emit    <= (i_item.row >= t_row'(2)) && (i_item.col >= t_col'(2));
                r_col.fend    <= i_item.fend;
                r_col.colsum  <= t_colsum'(up2) + t_colsum'(up1) + t_colsum'(i_item.sample);
                r_col.out_row <= i_item.row - t_row'(2);
                r_col.out_col <= i_item.col - t_col'(2);
            end
        end
    end

    assign o_col = r_col;

endmodule
